FILE: rtl/core/tfn_pkg.sv
// Package for the triangle face normal unit: widths and word types.
// No dependencies; the top level imports it.
`default_nettype none
package tfn_pkg;
	// Vertex coordinate width (signed fixed point, Q2.13 at 16 bits)
	localparam int COORD_W  = 16;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int EDGE_LIM = 24;
	localparam int EMAG_W   = (COORD_W < EDGE_LIM) ? COORD_W : EDGE_LIM;
	localparam int EFW      = EMAG_W + 1;
	localparam int FIT_W    = $clog2(COORD_W + 1);
	localparam int PROD_W   = 2 * EFW;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int CMAG_W   = 2 * EMAG_W + 1;
	localparam int POS_W    = $clog2(CMAG_W);
	localparam int NORM_W   = 30;
	localparam int SQ_W     = 2 * NORM_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int RT_W     = 64;
	localparam int RT_STEPS = 31;
	localparam int ROOT_W   = 31;
	localparam int FRAC_W   = 14;
	localparam int QUO_W    = FRAC_W + 1;
	localparam int REM_W    = ROOT_W + QUO_W;
	localparam int TAG_W    = 16;
	localparam int OUT_W    = 16;

	// Side data that travels with each word
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [2:0]       neg;
		logic             degen;
	} side_t;
endpackage
`default_nettype wire

FILE: rtl/core/triangle_face_normal_unit.sv
// Triangle face normal unit: edges, cross product, normalize, root and divide.
// Depends on tfn_pkg.
//
//  channel | valid     | stall     | fields
//  input   | in_valid  | in_stall  | cell_tag, v0_x..v2_z
//  output  | out_valid | out_stall | tag_out, normal_x/y/z, degenerate
//
// One word enters per cycle while in_stall is low; the pipeline holds 8 front
// stages, 31 root steps, 15 divide steps and the output register.
// The whole pipeline advances together when the output register is empty or taken;
// in_stall is high exactly while a held result waits under out_stall.
// Reset clears only the valid bits.
`default_nettype none
module triangle_face_normal_unit import tfn_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [TAG_W-1:0]          cell_tag,
	input  wire logic signed [COORD_W-1:0] v0_x,
	input  wire logic signed [COORD_W-1:0] v0_y,
	input  wire logic signed [COORD_W-1:0] v0_z,
	input  wire logic signed [COORD_W-1:0] v1_x,
	input  wire logic signed [COORD_W-1:0] v1_y,
	input  wire logic signed [COORD_W-1:0] v1_z,
	input  wire logic signed [COORD_W-1:0] v2_x,
	input  wire logic signed [COORD_W-1:0] v2_y,
	input  wire logic signed [COORD_W-1:0] v2_z,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [TAG_W-1:0]               tag_out,
	output logic signed [OUT_W-1:0]        normal_x,
	output logic signed [OUT_W-1:0]        normal_y,
	output logic signed [OUT_W-1:0]        normal_z,
	output logic                           degenerate
);
	logic en;
	logic signed [COORD_W-1:0] p0 [3];
	logic signed [COORD_W-1:0] p1 [3];
	logic signed [COORD_W-1:0] p2 [3];

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	assign p0[0] = v0_x; assign p0[1] = v0_y; assign p0[2] = v0_z;
	assign p1[0] = v1_x; assign p1[1] = v1_y; assign p1[2] = v1_z;
	assign p2[0] = v2_x; assign p2[1] = v2_y; assign p2[2] = v2_z;

	// valid bits of the front stages
	logic [8:1] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[7:1], in_valid};
		end
	end

	// Stage 1: edges
	logic signed [EDGE_W-1:0] e1_s1 [3];
	logic signed [EDGE_W-1:0] e2_s1 [3];
	logic [TAG_W-1:0]         tag_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= cell_tag;
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= {p1[i][COORD_W-1], p1[i]} - {p0[i][COORD_W-1], p0[i]};
				e2_s1[i] <= {p2[i][COORD_W-1], p2[i]} - {p1[i][COORD_W-1], p1[i]};
			end
		end
	end

	// Stage 2: fit each edge below the product width limit
	function automatic void fit_edge(input logic signed [EDGE_W-1:0] e [3],
	                                 output logic signed [EFW-1:0] f [3]);
		logic [COORD_W-1:0] m [3];
		logic [COORD_W-1:0] orv;
		logic [FIT_W-1:0]   sh;
		logic [COORD_W-1:0] fm;
		int                 msb;
		orv = '0;
		for (int i = 0; i < 3; i++) begin
			m[i] = e[i][EDGE_W-1] ? COORD_W'(-e[i]) : COORD_W'(e[i]);
			orv  = orv | m[i];
		end
		msb = 0;
		for (int b = 0; b < COORD_W; b++) begin
			if (orv[b]) msb = b;
		end
		sh = (msb >= EMAG_W) ? FIT_W'(msb - EMAG_W + 1) : '0;
		for (int i = 0; i < 3; i++) begin
			fm   = m[i] >> sh;
			f[i] = e[i][EDGE_W-1] ? -$signed({1'b0, fm[EMAG_W-1:0]})
			                      : $signed({1'b0, fm[EMAG_W-1:0]});
		end
	endfunction

	logic signed [EFW-1:0] f1_c [3];
	logic signed [EFW-1:0] f2_c [3];
	logic signed [EFW-1:0] e1_s2 [3];
	logic signed [EFW-1:0] e2_s2 [3];
	logic [TAG_W-1:0]      tag_s2;
	always_comb begin
		fit_edge(e1_s1, f1_c);
		fit_edge(e2_s1, f2_c);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			e1_s2  <= f1_c;
			e2_s2  <= f2_c;
		end
	end

	// Stage 3: six partial products of the cross product
	logic signed [PROD_W-1:0] pr_s3 [6];
	logic [TAG_W-1:0]         tag_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3   <= tag_s2;
			pr_s3[0] <= e1_s2[1] * e2_s2[2];
			pr_s3[1] <= e1_s2[2] * e2_s2[1];
			pr_s3[2] <= e1_s2[2] * e2_s2[0];
			pr_s3[3] <= e1_s2[0] * e2_s2[2];
			pr_s3[4] <= e1_s2[0] * e2_s2[1];
			pr_s3[5] <= e1_s2[1] * e2_s2[0];
		end
	end

	// Stage 4: cross product, split into sign and magnitude
	logic signed [CROSS_W-1:0] cr_c [3];
	logic [CMAG_W-1:0]         mag_s4 [3];
	logic [2:0]                neg_s4;
	logic [TAG_W-1:0]          tag_s4;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr_c[i] = {pr_s3[2*i][PROD_W-1], pr_s3[2*i]}
			        - {pr_s3[2*i+1][PROD_W-1], pr_s3[2*i+1]};
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4 <= tag_s3;
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= cr_c[i][CROSS_W-1];
				mag_s4[i] <= cr_c[i][CROSS_W-1] ? CMAG_W'(-cr_c[i]) : CMAG_W'(cr_c[i]);
			end
		end
	end

	// Stage 5: leading one of the largest magnitude
	logic [CMAG_W-1:0] orm_c;
	logic [POS_W-1:0]  pos_c;
	logic [POS_W-1:0]  pos_s5;
	logic [CMAG_W-1:0] mag_s5 [3];
	side_t             sd_s5;
	always_comb begin
		orm_c = mag_s4[0] | mag_s4[1] | mag_s4[2];
		pos_c = '0;
		for (int b = 0; b < CMAG_W; b++) begin
			if (orm_c[b]) pos_c = POS_W'(b);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s5       <= pos_c;
			mag_s5       <= mag_s4;
			sd_s5.tag    <= tag_s4;
			sd_s5.neg    <= neg_s4;
			sd_s5.degen  <= (orm_c == '0);
		end
	end

	// Stage 6: shift so the leading one lands on bit NORM_W-1
	logic [CMAG_W+NORM_W-1:0] ext_c [3];
	logic [NORM_W-1:0]        a_s6 [3];
	side_t                    sd_s6;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_c[i] = {mag_s5[i], {NORM_W{1'b0}}} >> ({1'b0, pos_s5} + 1'b1);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6 <= sd_s5;
			for (int i = 0; i < 3; i++) begin
				a_s6[i] <= ext_c[i][NORM_W-1:0];
			end
		end
	end

	// Stage 7: squares
	logic [SQ_W-1:0]   sq_s7 [3];
	logic [NORM_W-1:0] a_s7 [3];
	side_t             sd_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s7 <= sd_s6;
			a_s7  <= a_s6;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= a_s6[i] * a_s6[i];
			end
		end
	end

	// Stage 8: sum of squares
	logic [SUM_W-1:0]  sum_s8;
	logic [NORM_W-1:0] a_s8 [3];
	side_t             sd_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s8  <= sd_s7;
			a_s8   <= a_s7;
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		end
	end

	// Root pipeline: one result bit per stage
	logic [RT_W-1:0]   rt_rem_s [RT_STEPS+1];
	logic [RT_W-1:0]   rt_res_s [RT_STEPS+1];
	logic [NORM_W-1:0] rt_a_s   [RT_STEPS+1][3];
	side_t             rt_sd_s  [RT_STEPS+1];
	logic              rt_vld_s [RT_STEPS+1];

	assign rt_rem_s[0] = RT_W'(sum_s8);
	assign rt_res_s[0] = '0;
	assign rt_a_s[0]   = a_s8;
	assign rt_sd_s[0]  = sd_s8;
	assign rt_vld_s[0] = vld_s[8];

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_root
		localparam int BP = 2 * (RT_STEPS - 1 - k);
		logic [RT_W-1:0] trial;
		assign trial = rt_res_s[k] + (RT_W'(1) << BP);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k+1] <= rt_vld_s[k];
			end
		end
		// take the bit when the remainder covers the trial value
		always_ff @(posedge clk) begin
			if (en) begin
				rt_a_s[k+1]  <= rt_a_s[k];
				rt_sd_s[k+1] <= rt_sd_s[k];
				if (rt_rem_s[k] >= trial) begin
					rt_rem_s[k+1] <= rt_rem_s[k] - trial;
					rt_res_s[k+1] <= (rt_res_s[k] >> 1) + (RT_W'(1) << BP);
				end else begin
					rt_rem_s[k+1] <= rt_rem_s[k];
					rt_res_s[k+1] <= rt_res_s[k] >> 1;
				end
			end
		end
	end

	// Divide pipeline: three lanes, one quotient bit per stage
	logic [ROOT_W-1:0] root_c;
	logic [REM_W-1:0]  dv_rem_s [QUO_W+1][3];
	logic [QUO_W-1:0]  dv_quo_s [QUO_W+1][3];
	logic [ROOT_W-1:0] dv_den_s [QUO_W+1];
	side_t             dv_sd_s  [QUO_W+1];
	logic              dv_vld_s [QUO_W+1];

	assign root_c = rt_res_s[RT_STEPS][ROOT_W-1:0];
	for (genvar i = 0; i < 3; i++) begin : g_seed
		assign dv_rem_s[0][i] = {1'b0, rt_a_s[RT_STEPS][i], {FRAC_W{1'b0}}}
		                      + REM_W'(root_c >> 1);
		assign dv_quo_s[0][i] = '0;
	end
	assign dv_den_s[0] = root_c;
	assign dv_sd_s[0]  = rt_sd_s[RT_STEPS];
	assign dv_vld_s[0] = rt_vld_s[RT_STEPS];

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int QB = QUO_W - 1 - j;
		logic [REM_W-1:0] dshift;
		assign dshift = REM_W'(dv_den_s[j]) << QB;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end
		// subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[j+1] <= dv_den_s[j];
				dv_sd_s[j+1]  <= dv_sd_s[j];
				for (int i = 0; i < 3; i++) begin
					if (dv_rem_s[j][i] >= dshift) begin
						dv_rem_s[j+1][i] <= dv_rem_s[j][i] - dshift;
						dv_quo_s[j+1][i] <= dv_quo_s[j][i] | (QUO_W'(1) << QB);
					end else begin
						dv_rem_s[j+1][i] <= dv_rem_s[j][i];
						dv_quo_s[j+1][i] <= dv_quo_s[j][i];
					end
				end
			end
		end
	end

	// Output register: apply signs, zero the normal of a degenerate triangle
	logic signed [OUT_W-1:0] nrm_c [3];
	side_t                   fin_sd;
	assign fin_sd = dv_sd_s[QUO_W];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (fin_sd.degen) begin
				nrm_c[i] = '0;
			end else if (fin_sd.neg[i]) begin
				nrm_c[i] = -$signed({1'b0, dv_quo_s[QUO_W][i]});
			end else begin
				nrm_c[i] = $signed({1'b0, dv_quo_s[QUO_W][i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_out    <= fin_sd.tag;
			normal_x   <= nrm_c[0];
			normal_y   <= nrm_c[1];
			normal_z   <= nrm_c[2];
			degenerate <= fin_sd.degen;
		end
	end
endmodule
`default_nettype wire

FILE: tb/triangle_face_normal_unit_tb.sv
// Testbench for triangle_face_normal_unit: directed and random triangles,
// a scoreboard that predicts each unit normal, and random idling on both sides.
// Depends on tfn_pkg and the triangle_face_normal_unit RTL.
`default_nettype none
module triangle_face_normal_unit_tb;
	import tfn_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		logic [TAG_W-1:0] tag;
		coord_t           p[9];
	} tri_word_t;

	typedef struct {
		logic [TAG_W-1:0]        tag;
		logic signed [OUT_W-1:0] n[3];
		logic                    degen;
	} normal_word_t;

	// Scoreboard: predicts the normal of each accepted triangle, checks results
	class normal_scoreboard;
		normal_word_t pending[$];
		int           mismatches = 0;

		function automatic longint unsigned isqrt(longint unsigned s);
			longint unsigned res, bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > s)
				bitv >>= 2;
			while (bitv != 0) begin
				if (s >= res + bitv) begin
					s   -= res + bitv;
					res  = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// Shift an edge right until every magnitude is below the edge limit
		function automatic void fit_edge(ref longint e[3]);
			longint unsigned m[3];
			longint unsigned mx;
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = (e[i] < 0) ? -e[i] : e[i];
				if (m[i] > mx) mx = m[i];
			end
			while (mx >= (64'd1 << EDGE_LIM)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++) m[i] >>= 1;
			end
			for (int i = 0; i < 3; i++)
				e[i] = (e[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
		endfunction

		function automatic normal_word_t predict_normal(tri_word_t t);
			normal_word_t    w;
			longint          e1[3], e2[3], c[3];
			longint unsigned a[3];
			longint unsigned mx, s, r, q;
			for (int i = 0; i < 3; i++) begin
				e1[i] = longint'(t.p[3+i]) - longint'(t.p[i]);
				e2[i] = longint'(t.p[6+i]) - longint'(t.p[3+i]);
			end
			fit_edge(e1);
			fit_edge(e2);
			c[0] = e1[1] * e2[2] - e1[2] * e2[1];
			c[1] = e1[2] * e2[0] - e1[0] * e2[2];
			c[2] = e1[0] * e2[1] - e1[1] * e2[0];
			w.tag = t.tag;
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				a[i] = (c[i] < 0) ? -c[i] : c[i];
				if (a[i] > mx) mx = a[i];
			end
			// Zero cross product: zero normal, flag it
			if (mx == 0) begin
				for (int i = 0; i < 3; i++) w.n[i] = '0;
				w.degen = 1'b1;
				return w;
			end
			// Normalize the largest magnitude into [2^29, 2^30)
			while (mx >= (64'd1 << NORM_W)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++) a[i] >>= 1;
			end
			while (mx < (64'd1 << (NORM_W - 1))) begin
				mx <<= 1;
				for (int i = 0; i < 3; i++) a[i] <<= 1;
			end
			s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			r = isqrt(s);
			for (int i = 0; i < 3; i++) begin
				q = ((a[i] << FRAC_W) + (r >> 1)) / r;
				if (q > (64'd1 << FRAC_W)) q = 64'd1 << FRAC_W;
				if (c[i] < 0) q = -q;
				w.n[i] = q[OUT_W-1:0];
			end
			w.degen = 1'b0;
			return w;
		endfunction

		function void note_input(tri_word_t t);
			pending = {pending, predict_normal(t)};
		endfunction

		function void check_result(normal_word_t got);
			normal_word_t exp;
			bit           bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result word, tag %h", got.tag);
				return;
			end
			exp = pending.pop_front();
			bad = (got.tag !== exp.tag) || (got.degen !== exp.degen);
			for (int i = 0; i < 3; i++)
				if (got.n[i] !== exp.n[i]) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: tag %h/%h n %0d %0d %0d / %0d %0d %0d degen %b/%b",
						got.tag, exp.tag, got.n[0], got.n[1], got.n[2],
						exp.n[0], exp.n[1], exp.n[2], got.degen, exp.degen);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [TAG_W-1:0] cell_tag, tag_out;
	coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
	logic degenerate;

	normal_scoreboard sb = new();
	int idle_pct  = 0;
	int stall_pct = 0;
	bit hold_req  = 0;
	bit hold_used = 0;
	int hold_cnt  = 0;

	triangle_face_normal_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cell_tag(cell_tag),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.out_valid(out_valid), .out_stall(out_stall), .tag_out(tag_out),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Track accepted words on both channels
	always @(posedge clk) begin
		tri_word_t    t;
		normal_word_t r;
		if (arst_n && in_valid && !in_stall) begin
			t.tag = cell_tag;
			t.p   = '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z};
			sb.note_input(t);
		end
		if (arst_n && out_valid && !out_stall) begin
			r.tag   = tag_out;
			r.n     = '{normal_x, normal_y, normal_z};
			r.degen = degenerate;
			sb.check_result(r);
		end
	end

	// Receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_used) begin
			hold_cnt  = 300;
			hold_used = 1;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_word(tri_word_t t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cell_tag <= t.tag;
		{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} <=
			{t.p[0], t.p[1], t.p[2], t.p[3], t.p[4], t.p[5], t.p[6], t.p[7], t.p[8]};
		do @(posedge clk); while (in_stall);
	endtask

	// Pause until every expected word is back, then let the pipe empty
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic tri_word_t make_tri(logic [TAG_W-1:0] tag, int q[9]);
		tri_word_t t;
		t.tag = tag;
		for (int i = 0; i < 9; i++) t.p[i] = coord_t'(q[i]);
		return t;
	endfunction

	// Random triangle: mostly full range, some small, some collinear
	function automatic tri_word_t rand_tri();
		tri_word_t t;
		int        mode, k;
		int        d[3];
		mode  = $urandom_range(9);
		t.tag = TAG_W'($urandom);
		for (int i = 0; i < 9; i++) begin
			if (mode <= 5) t.p[i] = coord_t'($urandom);
			else t.p[i] = coord_t'($signed($urandom_range(127)) - 64);
		end
		if (mode >= 8) begin
			k = $signed($urandom_range(6)) - 3;
			for (int i = 0; i < 3; i++) begin
				d[i]      = $signed($urandom_range(200)) - 100;
				t.p[i]    = coord_t'($signed($urandom_range(8000)) - 4000);
				t.p[3+i]  = coord_t'(t.p[i] + d[i]);
				t.p[6+i]  = coord_t'(t.p[3+i] + (mode == 9 ? 0 : k * d[i]));
			end
		end
		return t;
	endfunction

	localparam int MX = 32767;
	localparam int MN = -32768;

	initial begin
		tri_word_t dir[$];
		arst_n   = 0;
		in_valid = 0;
		cell_tag = '0;
		{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, axis triangles, degenerate cases
		dir = {dir, make_tri(16'h0000, '{0, 0, 0, 0, 0, 0, 0, 0, 0})};
		dir = {dir, make_tri(16'hFFFF, '{MN, MN, MN, MN, MN, MN, MN, MN, MN})};
		dir = {dir, make_tri(16'h1234, '{MX, MX, MX, MX, MX, MX, MX, MX, MX})};
		dir = {dir, make_tri(16'h0001, '{0, 0, 0, 8192, 0, 0, 0, 8192, 0})};
		dir = {dir, make_tri(16'h0002, '{0, 0, 0, 0, 8192, 0, 0, 0, 8192})};
		dir = {dir, make_tri(16'h0003, '{0, 0, 0, 0, 0, 8192, 8192, 0, 0})};
		dir = {dir, make_tri(16'h0004, '{0, 0, 0, 0, 8192, 0, 8192, 0, 0})};
		dir = {dir, make_tri(16'h0005, '{MN, MN, MN, MX, MN, MN, MN, MX, MN})};
		dir = {dir, make_tri(16'h0006, '{MX, MN, MX, MN, MX, MN, MX, MX, MN})};
		dir = {dir, make_tri(16'h0007, '{MN, MX, MN, MX, MN, MX, MN, MN, MX})};
		dir = {dir, make_tri(16'h0008, '{1, 2, 3, 2, 4, 6, 3, 6, 9})};
		dir = {dir, make_tri(16'h0009, '{MN, MN, MN, 0, 0, 0, MX, MX, MX})};
		dir = {dir, make_tri(16'h000A, '{0, 0, 0, 1, 0, 0, 0, 1, 0})};
		dir = {dir, make_tri(16'h000B, '{0, 0, 0, 1, 0, 0, 0, 0, -1})};
		dir = {dir, make_tri(16'h000C, '{100, 100, 100, 100, 100, 100, 5, 6, 7})};
		dir = {dir, make_tri(16'h000D, '{MX, 0, 0, 0, MX, 0, 0, 0, MX})};
		dir = {dir, make_tri(16'h000E, '{MN, 0, 0, 0, MN, 0, 0, 0, MN})};
		foreach (dir[i]) send_word(dir[i]);
		drain();

		// Random phases with different idle and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 62) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 62) : 0;
			for (int n = 0; n < 400; n++) begin
				if (ph == 0 && n == 100) hold_req = 1;
				send_word(rand_tri());
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: triangle_face_normal_unit.f
rtl/core/tfn_pkg.sv
rtl/core/triangle_face_normal_unit.sv
tb/triangle_face_normal_unit_tb.sv
